### hdl/wpm_pkg.sv
// Package for the wildcard pattern matcher: sizes, symbol codes, item kinds and shared structs.
package wpm_pkg;

  // Pattern capacity and derived widths
  localparam int MaxPattern = 32;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int RowW       = MaxPattern + 1;

  // Stream widths
  localparam int SymW       = 8;
  localparam int InDataW    = 8;
  localparam int InUserW    = 2;
  localparam int OutDataW   = 8;
  localparam int OutUserW   = 1;

  // Pattern symbols with special meaning
  localparam logic [SymW-1:0] SymStar = 8'd42;
  localparam logic [SymW-1:0] SymAny  = 8'd63;

  // Match row after reset: empty pattern matches empty text
  localparam logic [RowW-1:0] RowReset = {{MaxPattern{1'b0}}, 1'b1};

  // Item kinds carried on the input tuser
  typedef enum logic [InUserW-1:0] {
    KindPattern = 2'd0,
    KindText    = 2'd1,
    KindFinish  = 2'd2
  } kind_e;

  // One input item
  typedef struct packed {
    logic [InUserW-1:0] kind;
    logic [SymW-1:0]    symbol;
  } item_t;

  // One result item
  typedef struct packed {
    logic matched;
    logic error;
  } result_t;

  // Stored pattern bytes, one per column
  typedef logic [MaxPattern-1:0][SymW-1:0] pattern_t;

endpackage

### hdl/wpm_row_update.sv
// Next match row for one text byte, all columns in parallel.
module wpm_row_update (
  input  wpm_pkg::pattern_t              pattern_i,
  input  logic [wpm_pkg::LenW-1:0]       length_i,
  input  logic [wpm_pkg::RowW-1:0]       row_i,
  input  logic [wpm_pkg::SymW-1:0]       symbol_i,
  output logic [wpm_pkg::RowW-1:0]       row_o
);

  logic [wpm_pkg::MaxPattern-1:0] gen;
  logic [wpm_pkg::MaxPattern-1:0] prop;
  logic [wpm_pkg::RowW-1:0]       op_a;
  logic [wpm_pkg::RowW-1:0]       op_b;
  logic [wpm_pkg::RowW-1:0]       sum;
  logic [wpm_pkg::RowW-1:0]       carry;

  // Per-column terms: a star column passes its left neighbor on (propagate),
  // every column can set itself from the old row (generate).
  always_comb begin
    for (int i = 0; i < wpm_pkg::MaxPattern; i++) begin
      logic col_en;
      logic is_star;
      logic hit;
      col_en  = (wpm_pkg::LenW'(i) < length_i);
      is_star = (pattern_i[i] == wpm_pkg::SymStar);
      hit     = (pattern_i[i] == wpm_pkg::SymAny) || (pattern_i[i] == symbol_i);
      gen[i]  = col_en & (is_star ? (row_i[i] | row_i[i+1]) : (hit & row_i[i]));
      prop[i] = col_en & is_star;
    end
  end

  // The left-to-right OR chain through star runs is a carry chain:
  // adding (gen|prop) and gen yields carry = gen | prop & carry_in.
  assign op_a  = {1'b0, gen | prop};
  assign op_b  = {1'b0, gen};
  assign sum   = op_a + op_b;
  assign carry = sum ^ op_a ^ op_b;

  // Column j takes the carry out of bit j-1; column 0 clears after any text
  assign row_o = {carry[wpm_pkg::MaxPattern:1], 1'b0};

endmodule

### hdl/wpm_state.sv
// Match state: pattern store, length, match row and flags, updated once per item.
module wpm_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  wpm_pkg::item_t   item_i,
  output wpm_pkg::result_t result_o
);

  wpm_pkg::pattern_t              pattern_q;
  logic [wpm_pkg::LenW-1:0]       length_q, length_d;
  logic [wpm_pkg::RowW-1:0]       row_q, row_d;
  logic                           text_seen_q, text_seen_d;
  logic                           error_q, error_d;
  logic [wpm_pkg::RowW-1:0]       text_row;
  logic                           store_full;
  logic                           store_we;

  assign store_full = (length_q >= wpm_pkg::LenW'(wpm_pkg::MaxPattern));

  wpm_row_update u_row_update (
    .pattern_i (pattern_q),
    .length_i  (length_q),
    .row_i     (row_q),
    .symbol_i  (item_i.symbol),
    .row_o     (text_row)
  );

  // Report path: last accepted column and the error flag
  assign result_o.matched = row_q[length_q];
  assign result_o.error   = error_q;

  // Next state per item kind
  always_comb begin
    length_d    = length_q;
    row_d       = row_q;
    text_seen_d = text_seen_q;
    error_d     = error_q;
    store_we    = 1'b0;
    if (fire_i) begin
      case (wpm_pkg::kind_e'(item_i.kind))
        wpm_pkg::KindPattern: begin
          if (text_seen_q || store_full) begin
            error_d = 1'b1;
          end else begin
            store_we = 1'b1;
            row_d[length_q + 1'b1] = (item_i.symbol == wpm_pkg::SymStar) ? row_q[length_q]
                                                                         : 1'b0;
            length_d = length_q + 1'b1;
          end
        end
        wpm_pkg::KindText: begin
          row_d       = text_row;
          text_seen_d = 1'b1;
        end
        wpm_pkg::KindFinish: begin
          length_d    = '0;
          row_d       = wpm_pkg::RowReset;
          text_seen_d = 1'b0;
          error_d     = 1'b0;
        end
        default: begin
          // unused kind: no change
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= '0;
      row_q       <= wpm_pkg::RowReset;
      text_seen_q <= 1'b0;
      error_q     <= 1'b0;
    end else begin
      length_q    <= length_d;
      row_q       <= row_d;
      text_seen_q <= text_seen_d;
      error_q     <= error_d;
    end
  end

  // Pattern bytes, payload only
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      pattern_q[length_q[wpm_pkg::IdxW-1:0]] <= item_i.symbol;
    end
  end

endmodule

### hdl/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: input register, match state, result register.
//
//  channel  dir  tdata (low bit up)     tuser (low bit up)
//  s_axis   in   symbol[7:0]            kind[1:0] (0 pattern, 1 text, 2 finish)
//  m_axis   out  matched, 7'b0          error
//
// One item per cycle while no finish is held (see below); each item is registered in the
// input register, and a finish result is loaded into the output register as the finish leaves it.
// The text update is a single 33-bit row step (compares plus one carry chain).
// Reset empties both registers and returns the row to "empty matches empty".
// A finish waits in the input register while the output register holds an
// untaken result, and the input stalls behind it; other kinds never wait.
module wildcard_pattern_matcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wpm_pkg::InDataW-1:0]   s_axis_tdata,   // symbol[7:0]
  input  logic [wpm_pkg::InUserW-1:0]   s_axis_tuser,   // kind[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wpm_pkg::OutDataW-1:0]  m_axis_tdata,   // matched, then zero fill
  output logic [wpm_pkg::OutUserW-1:0]  m_axis_tuser    // error
);

  logic              in_valid_q;
  wpm_pkg::item_t    in_item_q;
  logic              out_valid_q;
  wpm_pkg::result_t  out_q;
  wpm_pkg::result_t  result;
  logic              is_finish;
  logic              out_free;
  logic              advance;
  logic              s_fire;

  // Handshake: only a finish needs room in the output register
  assign is_finish     = (wpm_pkg::kind_e'(in_item_q.kind) == wpm_pkg::KindFinish);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!is_finish || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.kind   <= s_axis_tuser;
      in_item_q.symbol <= s_axis_tdata[wpm_pkg::SymW-1:0];
    end
  end

  wpm_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_finish) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(wpm_pkg::OutDataW-1){1'b0}}, out_q.matched};
  assign m_axis_tuser  = out_q.error;

endmodule

### hdl/wpm_checker.sv
// Port-level checks for the wildcard pattern matcher, bound to the top level.
module wpm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [wpm_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [wpm_pkg::OutUserW-1:0]  m_axis_tuser
);

  // Input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped before transaction");

  // A pending result keeps its payload until taken
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result payload changed while stalled");

  // Result fill bits stay zero
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[wpm_pkg::OutDataW-1:1] == '0))
    else $error("nonzero fill in result data");

  // Nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (!m_axis_tvalid && s_axis_tready))
    else $error("state not empty after reset");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);
